/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property, disabled while reset is high.
`define GSE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked property that is also evaluated during reset.
`define GSE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/gse_pkg.sv */
// Package with types, constants and codes of the segment evictor.
`timescale 1ns / 1ps
`default_nettype none
package gse_pkg;

   localparam int DEPTH     = 32;
   localparam int AW        = $clog2(DEPTH);
   localparam int CW        = AW + 1;
   localparam int MAX_USAGE = 5;
   localparam int UW        = 3;
   localparam int IDW       = 64;
   localparam int SZW       = 48;
   localparam int TW        = 53;

   localparam logic KIND_EVICT = 1'b0;
   localparam logic KIND_FINAL = 1'b1;

   typedef enum logic [1:0] {
      OP_PUT    = 2'd0,
      OP_HIT    = 2'd1,
      OP_REMOVE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_OVER    = 2'd1,
      ST_FULL    = 2'd2,
      ST_MISSING = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_CMP,
      S_WALK,
      S_VIC,
      S_MOVE
   } state_type;

   typedef struct packed {
      logic [IDW-1:0] id;
      logic [UW-1:0]  usage;
      logic [SZW-1:0] size;
   } entry_type;

   typedef struct packed {
      logic            we;
      logic [AW-1:0]   waddr;
      entry_type       wdata;
      logic [AW-1:0]   raddr;
   } mem_req_type;

endpackage
`default_nettype wire

/* rtl/gse_mem.sv */
// Segment table memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module gse_mem (
   input  wire logic               clock,
   input  wire gse_pkg::mem_req_type mem_req,
   output gse_pkg::entry_type      rdata_ff
);

   gse_pkg::entry_type mem [gse_pkg::DEPTH];

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.waddr] <= mem_req.wdata;
      end
      rdata_ff <= mem[mem_req.raddr];
   end

endmodule
`default_nettype wire

/* rtl/gse_ctrl.sv */
// Sequencer: table search, clock-hand eviction walk, removal and results.
`timescale 1ns / 1ps
`default_nettype none
module gse_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [1:0]                    req_op,
   input  wire logic signed [gse_pkg::IDW-1:0] req_segment,
   input  wire logic [gse_pkg::SZW-1:0]       req_seg_bytes,
   input  wire logic [gse_pkg::SZW-1:0]       budget,
   output gse_pkg::mem_req_type               mem_req,
   input  wire gse_pkg::entry_type            mem_rdata,
   output logic                               rsp_valid,
   output logic                               rsp_kind,
   output logic signed [gse_pkg::IDW-1:0]     rsp_victim,
   output logic [gse_pkg::SZW-1:0]            rsp_victim_bytes,
   output logic [1:0]                         rsp_status,
   output logic [gse_pkg::TW-1:0]             rsp_total_bytes,
   output logic                               rsp_last
);

   localparam int AW  = gse_pkg::AW;
   localparam int CW  = gse_pkg::CW;
   localparam int TW  = gse_pkg::TW;
   localparam int SZW = gse_pkg::SZW;
   localparam int IDW = gse_pkg::IDW;
   localparam int UW  = gse_pkg::UW;

   gse_pkg::state_type state_ff, state_in;
   gse_pkg::op_type    op_ff, op_in;
   logic [IDW-1:0]     seg_ff, seg_in;
   logic [SZW-1:0]     bytes_ff, bytes_in;
   logic [CW-1:0]      scan_ff, scan_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [AW-1:0]      hand_ff, hand_in;
   logic [TW-1:0]      total_ff, total_in;
   logic [IDW-1:0]     vic_id_ff, vic_id_in;
   logic [SZW-1:0]     vic_sz_ff, vic_sz_in;
   logic [AW-1:0]      move_idx_ff, move_idx_in;
   logic               evict_ff, evict_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_kind_ff, rsp_kind_in;
   logic [IDW-1:0]     rsp_victim_ff, rsp_victim_in;
   logic [SZW-1:0]     rsp_vbytes_ff, rsp_vbytes_in;
   gse_pkg::status_type rsp_status_ff, rsp_status_in;
   logic               rsp_last_ff, rsp_last_in;
   logic [TW-1:0]      rsp_total_ff;

   logic               over;
   logic [AW-1:0]      hand_wrap;
   logic [AW-1:0]      hand_next;
   logic [UW-1:0]      usage_bump;
   logic [CW-1:0]      count_dec;

   // Hand position after the entry at idx is dropped from the table.
   function automatic logic [AW-1:0] hand_after_drop(input logic [AW-1:0] idx,
                                                     input logic [AW-1:0] hand,
                                                     input logic [CW-1:0] newcnt);
      logic [AW-1:0] res;
      if (newcnt == '0) begin
         res = '0;
      end else if (idx < hand) begin
         res = hand - AW'(1);
      end else if (CW'(hand) >= newcnt) begin
         res = '0;
      end else begin
         res = hand;
      end
      return res;
   endfunction

   function automatic logic [TW-1:0] sat_sub(input logic [TW-1:0] total,
                                            input logic [SZW-1:0] size);
      logic [TW-1:0] res;
      if (TW'(size) > total) begin
         res = '0;
      end else begin
         res = total - TW'(size);
      end
      return res;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gse_pkg::S_IDLE;
         count_ff     <= '0;
         hand_ff      <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         hand_ff      <= hand_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      seg_ff        <= seg_in;
      bytes_ff      <= bytes_in;
      scan_ff       <= scan_in;
      vic_id_ff     <= vic_id_in;
      vic_sz_ff     <= vic_sz_in;
      move_idx_ff   <= move_idx_in;
      evict_ff      <= evict_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_victim_ff <= rsp_victim_in;
      rsp_vbytes_ff <= rsp_vbytes_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_total_ff  <= total_in;
   end

   assign over = (budget != '0) && (total_ff > TW'(budget));
   assign hand_wrap = (CW'(hand_ff) >= count_ff) ? '0 : hand_ff;
   assign hand_next = ((CW'(hand_ff) + CW'(1)) == count_ff) ? '0 : hand_ff + AW'(1);
   assign usage_bump = (mem_rdata.usage < UW'(gse_pkg::MAX_USAGE)) ?
                       mem_rdata.usage + UW'(1) : mem_rdata.usage;
   assign count_dec = count_ff - CW'(1);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      seg_in        = seg_ff;
      bytes_in      = bytes_ff;
      scan_in       = scan_ff;
      count_in      = count_ff;
      hand_in       = hand_ff;
      total_in      = total_ff;
      vic_id_in     = vic_id_ff;
      vic_sz_in     = vic_sz_ff;
      move_idx_in   = move_idx_ff;
      evict_in      = evict_ff;
      rsp_valid_in  = 1'b0;
      rsp_kind_in   = gse_pkg::KIND_FINAL;
      rsp_victim_in = '0;
      rsp_vbytes_in = '0;
      rsp_status_in = gse_pkg::ST_OK;
      rsp_last_in   = 1'b1;
      mem_req       = '0;

      case (state_ff)
         gse_pkg::S_IDLE: begin
            if (start) begin
               op_in    = gse_pkg::op_type'(req_op);
               seg_in   = req_segment;
               bytes_in = req_seg_bytes;
               scan_in  = '0;
               if (gse_pkg::op_type'(req_op) == gse_pkg::OP_CLEAR) begin
                  count_in     = '0;
                  hand_in      = '0;
                  total_in     = '0;
                  rsp_valid_in = 1'b1;
               end else begin
                  state_in = gse_pkg::S_SEARCH;
               end
            end
         end
         gse_pkg::S_SEARCH: begin
            if (scan_ff == count_ff) begin
               // The segment is not in the table.
               if (op_ff == gse_pkg::OP_PUT) begin
                  if (count_ff == CW'(gse_pkg::DEPTH)) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = gse_pkg::ST_FULL;
                     state_in      = gse_pkg::S_IDLE;
                  end else begin
                     mem_req.we          = 1'b1;
                     mem_req.waddr       = count_ff[AW-1:0];
                     mem_req.wdata.id    = seg_ff;
                     mem_req.wdata.usage = UW'(1);
                     mem_req.wdata.size  = bytes_ff;
                     count_in = count_ff + CW'(1);
                     total_in = total_ff + TW'(bytes_ff);
                     state_in = gse_pkg::S_WALK;
                  end
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = gse_pkg::ST_MISSING;
                  state_in      = gse_pkg::S_IDLE;
               end
            end else begin
               mem_req.raddr = scan_ff[AW-1:0];
               state_in      = gse_pkg::S_CMP;
            end
         end
         gse_pkg::S_CMP: begin
            if (mem_rdata.id == seg_ff) begin
               case (op_ff)
                  gse_pkg::OP_PUT: begin
                     mem_req.we          = 1'b1;
                     mem_req.waddr       = scan_ff[AW-1:0];
                     mem_req.wdata.id    = mem_rdata.id;
                     mem_req.wdata.usage = usage_bump;
                     mem_req.wdata.size  = bytes_ff;
                     total_in = total_ff - TW'(mem_rdata.size) + TW'(bytes_ff);
                     state_in = gse_pkg::S_WALK;
                  end
                  gse_pkg::OP_HIT: begin
                     mem_req.we          = 1'b1;
                     mem_req.waddr       = scan_ff[AW-1:0];
                     mem_req.wdata       = mem_rdata;
                     mem_req.wdata.usage = usage_bump;
                     rsp_valid_in = 1'b1;
                     state_in     = gse_pkg::S_IDLE;
                  end
                  gse_pkg::OP_REMOVE: begin
                     vic_sz_in   = mem_rdata.size;
                     move_idx_in = scan_ff[AW-1:0];
                     evict_in    = 1'b0;
                     if (scan_ff == count_dec) begin
                        count_in = count_dec;
                        total_in = sat_sub(total_ff, mem_rdata.size);
                        hand_in  = hand_after_drop(scan_ff[AW-1:0], hand_ff, count_dec);
                        rsp_valid_in = 1'b1;
                        state_in     = gse_pkg::S_IDLE;
                     end else begin
                        mem_req.raddr = count_dec[AW-1:0];
                        state_in      = gse_pkg::S_MOVE;
                     end
                  end
                  default: begin
                     state_in = gse_pkg::S_IDLE;
                  end
               endcase
            end else begin
               scan_in  = scan_ff + CW'(1);
               state_in = gse_pkg::S_SEARCH;
            end
         end
         gse_pkg::S_WALK: begin
            // The put segment is present, so another entry exists iff count > 1.
            if (over && (count_ff > CW'(1))) begin
               hand_in       = hand_wrap;
               mem_req.raddr = hand_wrap;
               state_in      = gse_pkg::S_VIC;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = over ? gse_pkg::ST_OVER : gse_pkg::ST_OK;
               state_in      = gse_pkg::S_IDLE;
            end
         end
         gse_pkg::S_VIC: begin
            if (mem_rdata.id == seg_ff) begin
               hand_in  = hand_next;
               state_in = gse_pkg::S_WALK;
            end else if (mem_rdata.usage != '0) begin
               mem_req.we          = 1'b1;
               mem_req.waddr       = hand_ff;
               mem_req.wdata       = mem_rdata;
               mem_req.wdata.usage = mem_rdata.usage - UW'(1);
               hand_in  = hand_next;
               state_in = gse_pkg::S_WALK;
            end else begin
               vic_id_in = mem_rdata.id;
               vic_sz_in = mem_rdata.size;
               if (CW'(hand_ff) == count_dec) begin
                  count_in      = count_dec;
                  total_in      = sat_sub(total_ff, mem_rdata.size);
                  hand_in       = hand_after_drop(hand_ff, hand_ff, count_dec);
                  rsp_valid_in  = 1'b1;
                  rsp_kind_in   = gse_pkg::KIND_EVICT;
                  rsp_victim_in = mem_rdata.id;
                  rsp_vbytes_in = mem_rdata.size;
                  rsp_last_in   = 1'b0;
                  state_in      = gse_pkg::S_WALK;
               end else begin
                  mem_req.raddr = count_dec[AW-1:0];
                  move_idx_in   = hand_ff;
                  evict_in      = 1'b1;
                  state_in      = gse_pkg::S_MOVE;
               end
            end
         end
         gse_pkg::S_MOVE: begin
            // The last entry fills the freed slot.
            mem_req.we    = 1'b1;
            mem_req.waddr = move_idx_ff;
            mem_req.wdata = mem_rdata;
            count_in = count_dec;
            total_in = sat_sub(total_ff, vic_sz_ff);
            hand_in  = hand_after_drop(move_idx_ff, hand_ff, count_dec);
            rsp_valid_in = 1'b1;
            if (evict_ff) begin
               rsp_kind_in   = gse_pkg::KIND_EVICT;
               rsp_victim_in = vic_id_ff;
               rsp_vbytes_in = vic_sz_ff;
               rsp_last_in   = 1'b0;
               state_in      = gse_pkg::S_WALK;
            end else begin
               state_in = gse_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = gse_pkg::S_IDLE;
         end
      endcase
   end

   assign busy             = (state_ff != gse_pkg::S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_victim       = $signed(rsp_victim_ff);
   assign rsp_victim_bytes = rsp_vbytes_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_total_bytes  = rsp_total_ff;
   assign rsp_last         = rsp_last_ff;

endmodule
`default_nettype wire

/* rtl/gclock_segment_evictor.sv */
// Top level: register port, segment table memory and sequencer.
// Steps: each table entry scanned by the search is read and compared (S_SEARCH,
// S_CMP); each hand step of the eviction walk is S_WALK then S_VIC, and an
// eviction adds S_MOVE unless it is the last entry; result beats are registered.
// One item at a time; busy stays high until the final beat is launched.
// Synchronous reset empties the table, zeroes hand, total and budget.
`timescale 1ns / 1ps
`default_nettype none
module gclock_segment_evictor (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic [1:0]                     req_op,
   input  wire logic signed [gse_pkg::IDW-1:0] req_segment,
   input  wire logic [gse_pkg::SZW-1:0]        req_seg_bytes,
   output logic                                rsp_valid,
   output logic                                rsp_kind,
   output logic signed [gse_pkg::IDW-1:0]      rsp_victim,
   output logic [gse_pkg::SZW-1:0]             rsp_victim_bytes,
   output logic [1:0]                          rsp_status,
   output logic [gse_pkg::TW-1:0]              rsp_total_bytes,
   output logic                                rsp_last,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [2:0]                     paddr,
   input  wire logic [63:0]                    pwdata,
   output logic [63:0]                         prdata,
   output logic                                pready
);

   logic [gse_pkg::SZW-1:0] budget_ff;
   gse_pkg::mem_req_type    mem_req;
   gse_pkg::entry_type      mem_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff <= '0;
      end else if (psel && penable && pwrite && pready && (paddr == 3'd0)) begin
         budget_ff <= pwdata[gse_pkg::SZW-1:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr == 3'd0) ? 64'(budget_ff) : '0;

   gse_mem u_mem (
      .clock    (clock),
      .mem_req  (mem_req),
      .rdata_ff (mem_rdata)
   );

   gse_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_segment      (req_segment),
      .req_seg_bytes    (req_seg_bytes),
      .budget           (budget_ff),
      .mem_req          (mem_req),
      .mem_rdata        (mem_rdata),
      .rsp_valid        (rsp_valid),
      .rsp_kind         (rsp_kind),
      .rsp_victim       (rsp_victim),
      .rsp_victim_bytes (rsp_victim_bytes),
      .rsp_status       (rsp_status),
      .rsp_total_bytes  (rsp_total_bytes),
      .rsp_last         (rsp_last)
   );

endmodule
`default_nettype wire

/* rtl/gse_checker.sv */
// Port-level checker for the segment evictor and its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module gse_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic        rsp_kind,
   input wire logic [63:0] rsp_victim,
   input wire logic [47:0] rsp_victim_bytes,
   input wire logic [1:0]  rsp_status,
   input wire logic        rsp_last
);

   // A final beat is always the last one and carries no victim.
   `GSE_ASSERT(a_final_last, clock, reset, rsp_valid && (rsp_kind == gse_pkg::KIND_FINAL) |-> rsp_last && (rsp_victim == '0) && (rsp_victim_bytes == '0), "final beat malformed")
   // An eviction beat reports ok status and is never the last beat.
   `GSE_ASSERT(a_evict_ok, clock, reset, rsp_valid && (rsp_kind == gse_pkg::KIND_EVICT) |-> !rsp_last && (rsp_status == gse_pkg::ST_OK), "eviction beat malformed")
   // The block only goes busy because an item was started.
   `GSE_ASSERT(a_busy_cause, clock, reset, $rose(busy) |-> $past(start), "busy without start")
   // After the last beat of an item the block is free again.
   `GSE_ASSERT(a_last_free, clock, reset, rsp_valid && rsp_last |-> !busy || $past(start && !busy), "busy after final beat")
   // Reset leaves the block idle with no beat.
   `GSE_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !busy && !rsp_valid, "not idle after reset")

endmodule

bind gclock_segment_evictor gse_checker u_gse_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_kind         (rsp_kind),
   .rsp_victim       (rsp_victim),
   .rsp_victim_bytes (rsp_victim_bytes),
   .rsp_status       (rsp_status),
   .rsp_last         (rsp_last)
);
`default_nettype wire
